### sv/amsd_pkg.sv
// shared types and constants of the accelerometer magnitude step detector
// used by amsd_mag_sq and accel_magnitude_step_detector; no dependencies
package amsd_pkg;

	localparam int AXIS_W      = 16;  // width of one axis field on the stream
	localparam int MAG_W       = 32;  // squared magnitude
	localparam int COUNT_W     = 32;  // step counter
	localparam int MOTION_W    = 12;  // motion level
	localparam int COOL_W      = 8;   // cooldown counter
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// divide by one million as (x >> 6) / 15625, the latter by reciprocal multiply
	localparam int DIV_PRE_SHIFT          = 6;
	localparam int DIV_IN_W               = MAG_W - DIV_PRE_SHIFT;
	localparam int DIV_RECIP_W            = 27;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 27'd70368745;  // ceil(2^40 / 15625)
	localparam int DIV_POST_SHIFT         = 40;
	localparam int DIV_PROD_W             = DIV_IN_W + DIV_RECIP_W;

	localparam logic [MAG_W-1:0]  HIGH_THR_RESET  = 32'd420000000;
	localparam logic [MAG_W-1:0]  LOW_THR_RESET   = 32'd330000000;
	localparam logic [COOL_W-1:0] COOLDOWN_RESET  = 8'd1;
	localparam logic [MOTION_W-1:0] MOTION_MAX    = 12'd3221;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIGH_THR = 2'd0,
		REG_LOW_THR  = 2'd1,
		REG_COOLDOWN = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

endpackage

### sv/amsd_mag_sq.sv
// squared magnitude of a three-axis sample: three parallel squares and a sum
// depends on amsd_pkg for field and result widths
module amsd_mag_sq #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic [amsd_pkg::AXIS_W-1:0] accel_x,
	input  logic [amsd_pkg::AXIS_W-1:0] accel_y,
	input  logic [amsd_pkg::AXIS_W-1:0] accel_z,
	output logic [amsd_pkg::MAG_W-1:0]  mag_sq
);
	import amsd_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0]   sx, sy, sz;
	logic signed [2*SAMPLE_WIDTH-1:0] px, py, pz;
	logic [MAG_W-1:0]                 ux, uy, uz;

	// only the low sample bits count, taken as two's complement
	assign sx = $signed(accel_x[SAMPLE_WIDTH-1:0]);
	assign sy = $signed(accel_y[SAMPLE_WIDTH-1:0]);
	assign sz = $signed(accel_z[SAMPLE_WIDTH-1:0]);

	assign px = sx * sx;
	assign py = sy * sy;
	assign pz = sz * sz;

	// squares are never negative
	assign ux = MAG_W'($unsigned(px));
	assign uy = MAG_W'($unsigned(py));
	assign uz = MAG_W'($unsigned(pz));

	assign mag_sq = ux + uy + uz;

endmodule

### sv/accel_magnitude_step_detector.sv
// top level of the accelerometer magnitude step detector: stream ports,
// pipeline, step state and register file; uses amsd_pkg and amsd_mag_sq
//
// usage
//   s_axis carries one transaction per item: tdata holds the three signed axis
//   samples, tuser the opcode (sample or clear of the step count)
//   m_axis returns exactly one transaction per input item, in order, with the
//   step count, the motion level (squared magnitude / 1e6), the active flag
//   and a flag for a step counted by this item
//   the cfg channel writes the high threshold, low threshold and cooldown
//   reload by index; cfg_ready is always high, unknown indices are dropped
// timing
//   three register stages: input register, squared magnitude register and
//   result register, in that order
//   one item per cycle sustained while m_axis_tready is high; the three squares
//   and the sum fill the first stage, the reciprocal multiply for the divide by
//   one million and the threshold compares fill the second
// reset and stalls
//   arst_n clears the pipeline, the step state and loads the register defaults
//   when m_axis_tready is low each stage keeps its item and bubbles close up;
//   s_axis_tready drops only once all three stages hold items
module accel_magnitude_step_detector #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
	input  logic [amsd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [0] opcode
	input  logic                               s_axis_tuser,

	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] step_total, [43:32] motion_level, [44] step_in_progress,
	// [45] step_counted, [47:46] zero
	output logic [amsd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [amsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [amsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import amsd_pkg::*;

	// configuration registers
	logic [MAG_W-1:0]    high_thr_q;
	logic [MAG_W-1:0]    low_thr_q;
	logic [COOL_W-1:0]   cool_cfg_q;

	// stage 1: accepted item
	logic                valid_s1;
	logic                opcode_s1;
	logic [AXIS_W-1:0]   ax_s1, ay_s1, az_s1;

	// stage 2: squared magnitude
	logic                valid_s2;
	logic                opcode_s2;
	logic [MAG_W-1:0]    mag_sq_s2;
	logic [MAG_W-1:0]    mag_sq_comb;

	// step state
	logic [COUNT_W-1:0]  step_cnt_q;
	logic                active_q;
	logic [COOL_W-1:0]   cooldown_q;
	logic [MOTION_W-1:0] last_motion_q;

	// result register
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_total_q;
	logic [MOTION_W-1:0] out_motion_q;
	logic                out_active_q;
	logic                out_counted_q;

	// handshake chain
	logic                out_ready;
	logic                ready_s2;
	logic                adv_s2;

	// next-state values
	logic [DIV_IN_W-1:0]   div_in;
	logic [DIV_PROD_W-1:0] div_prod;
	logic [MOTION_W-1:0]   quotient;
	logic [COOL_W-1:0]     cool_dec;
	logic [COUNT_W-1:0]    step_cnt_nxt;
	logic                  active_nxt;
	logic [COOL_W-1:0]     cooldown_nxt;
	logic [MOTION_W-1:0]   motion_nxt;
	logic                  counted_nxt;

	// each stage takes a new item when empty or when its item moves on
	assign out_ready     = !out_valid_q || m_axis_tready;
	assign ready_s2      = !valid_s2 || out_ready;
	assign s_axis_tready = !valid_s1 || ready_s2;
	assign adv_s2        = valid_s2 && out_ready;
	assign cfg_ready     = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_THR_RESET;
			low_thr_q  <= LOW_THR_RESET;
			cool_cfg_q <= COOLDOWN_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_HIGH_THR: high_thr_q <= cfg_data;
				REG_LOW_THR:  low_thr_q  <= cfg_data;
				REG_COOLDOWN: cool_cfg_q <= cfg_data[COOL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			opcode_s1 <= s_axis_tuser;
			ax_s1     <= s_axis_tdata[AXIS_W-1:0];
			ay_s1     <= s_axis_tdata[2*AXIS_W-1:AXIS_W];
			az_s1     <= s_axis_tdata[3*AXIS_W-1:2*AXIS_W];
		end
	end

	amsd_mag_sq #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mag_sq (
		.accel_x (ax_s1),
		.accel_y (ay_s1),
		.accel_z (az_s1),
		.mag_sq  (mag_sq_comb)
	);

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			opcode_s2 <= opcode_s1;
			mag_sq_s2 <= mag_sq_comb;
		end
	end

	// divide by one million: drop six bits, then multiply by 2^40/15625
	assign div_in   = mag_sq_s2[MAG_W-1:DIV_PRE_SHIFT];
	assign div_prod = DIV_PROD_W'(div_in) * DIV_PROD_W'(DIV_RECIP);
	assign quotient = div_prod[DIV_POST_SHIFT+MOTION_W-1:DIV_POST_SHIFT];

	// cooldown stops at zero
	assign cool_dec = (cooldown_q != '0) ? cooldown_q - COOL_W'(1) : '0;

	// step detector update for the item leaving stage 2
	always_comb begin
		step_cnt_nxt = step_cnt_q;
		active_nxt   = active_q;
		cooldown_nxt = cooldown_q;
		motion_nxt   = last_motion_q;
		counted_nxt  = 1'b0;
		if (opcode_t'(opcode_s2) == OP_CLEAR) begin
			step_cnt_nxt = '0;
		end else begin
			motion_nxt   = quotient;
			cooldown_nxt = cool_dec;
			if (active_q) begin
				if (mag_sq_s2 < low_thr_q) begin
					active_nxt = 1'b0;
				end
			end else if (cool_dec == '0 && mag_sq_s2 > high_thr_q) begin
				step_cnt_nxt = step_cnt_q + COUNT_W'(1);
				active_nxt   = 1'b1;
				cooldown_nxt = cool_cfg_q;
				counted_nxt  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q    <= '0;
			active_q      <= 1'b0;
			cooldown_q    <= '0;
			last_motion_q <= '0;
		end else if (adv_s2) begin
			step_cnt_q    <= step_cnt_nxt;
			active_q      <= active_nxt;
			cooldown_q    <= cooldown_nxt;
			last_motion_q <= motion_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			out_total_q   <= step_cnt_nxt;
			out_motion_q  <= motion_nxt;
			out_active_q  <= active_nxt;
			out_counted_q <= counted_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_counted_q, out_active_q, out_motion_q, out_total_q};

`ifndef NO_ASSERTIONS
	// a counted step always leaves the detector active
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_counted_q |-> out_active_q)
		else $error("step counted without active flag");

	// a counted step reloads the cooldown from its register
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && counted_nxt |=> cooldown_q == $past(cool_cfg_q))
		else $error("cooldown not reloaded after counted step");

	// motion level never exceeds the largest squared magnitude over one million
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_motion_q <= MOTION_MAX)
		else $error("motion level out of range");

	// step state moves only with an item leaving stage 2
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 |=> $stable(step_cnt_q) && $stable(active_q) && $stable(cooldown_q))
		else $error("step state changed without an item");
`endif

endmodule

### test/tb_accel_magnitude_step_detector.sv
// self-checking testbench for accel_magnitude_step_detector: directed and random
// samples through the stream ports, register writes between phases, own step model
// depends on amsd_pkg and the accel_magnitude_step_detector rtl
module tb_accel_magnitude_step_detector;
	import amsd_pkg::*;

	// spare register index, the block must drop writes to it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [MAG_W-1:0] MOTION_DIV = 32'd1000000;

	// one input transaction: opcode in tuser, axes in tdata (x lowest)
	typedef struct packed {
		opcode_t     op;
		logic [15:0] az;
		logic [15:0] ay;
		logic [15:0] ax;
	} sample_item_t;

	// one output transaction, laid out as on m_axis_tdata[45:0]
	typedef struct packed {
		logic                counted;
		logic                in_progress;
		logic [MOTION_W-1:0] motion;
		logic [COUNT_W-1:0]  total;
	} step_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    s_axis_tuser = OP_SAMPLE;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// model copy of the register file
	logic [MAG_W-1:0]    thr_high = HIGH_THR_RESET;
	logic [MAG_W-1:0]    thr_low = LOW_THR_RESET;
	logic [COOL_W-1:0]   cool_reload = COOLDOWN_RESET;
	// model copy of the step state
	logic [COUNT_W-1:0]  steps = '0;
	logic                step_active = 1'b0;
	logic [COOL_W-1:0]   cool_left = '0;
	logic [MOTION_W-1:0] held_motion = '0;

	sample_item_t items_to_send[$];   // waiting for the driver
	step_result_t results_due[$];     // predicted, not yet seen on m_axis

	int  mismatches = 0;
	int  stall_pct = 0;               // chance per cycle of starting a stall burst
	int  src_gap = 0;
	int  snk_gap = 0;
	logic src_took = 1'b0;            // s_axis transaction at the last rising edge
	logic drained = 1'b0;             // nothing queued, in flight or expected

	accel_magnitude_step_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// step detector behavior: updates the model state, returns the result of one item
	function automatic step_result_t predict_step(sample_item_t it);
		step_result_t r;
		longint       sq;
		logic [MAG_W-1:0] mag;
		r.counted = 1'b0;
		if (it.op == OP_CLEAR) begin
			// clear touches only the count
			steps = '0;
		end else begin
			sq = longint'($signed(it.ax)) * $signed(it.ax)
				+ longint'($signed(it.ay)) * $signed(it.ay)
				+ longint'($signed(it.az)) * $signed(it.az);
			mag = sq[MAG_W-1:0];
			held_motion = MOTION_W'(mag / MOTION_DIV);
			if (cool_left != 0) begin
				cool_left = cool_left - COOL_W'(1);
			end
			if (step_active) begin
				// active step ends strictly below the low threshold
				if (mag < thr_low) begin
					step_active = 1'b0;
				end
			end else if (cool_left == 0 && mag > thr_high) begin
				steps = steps + COUNT_W'(1);
				step_active = 1'b1;
				cool_left = cool_reload;
				r.counted = 1'b1;
			end
		end
		r.total = steps;
		r.motion = held_motion;
		r.in_progress = step_active;
		return r;
	endfunction

	function automatic sample_item_t mk_item(opcode_t op, int x, int y, int z);
		sample_item_t it;
		it.op = op;
		it.ax = 16'(x);
		it.ay = 16'(y);
		it.az = 16'(z);
		return it;
	endfunction

	function automatic logic [15:0] signed_axis(int mag);
		if ($urandom_range(0, 1) == 1) begin
			return 16'(-mag);
		end
		return 16'(mag);
	endfunction

	// one strong axis of the given magnitude, the other two small
	function automatic sample_item_t dominant_sample(int mag, int spread);
		sample_item_t it;
		int m;
		m = (mag > 32767) ? 32767 : ((mag < 0) ? 0 : mag);
		it.op = OP_SAMPLE;
		it.ax = signed_axis($urandom_range(0, spread));
		it.ay = signed_axis($urandom_range(0, spread));
		it.az = signed_axis($urandom_range(0, spread));
		case ($urandom_range(0, 2))
			0: it.ax = signed_axis(m);
			1: it.ay = signed_axis(m);
			default: it.az = signed_axis(m);
		endcase
		return it;
	endfunction

	function automatic logic [15:0] corner_axis();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'hFFFF;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	// single-axis value whose square lies near a threshold
	function automatic int axis_root(logic [MAG_W-1:0] thr);
		real r;
		r = $sqrt(real'(thr));
		if (r > 32767.0) begin
			return 32767;
		end
		return int'(r);
	endfunction

	// mostly whole steps (strong samples then quiet ones), plus noise, corners and clears
	task automatic queue_random(int n);
		int hr;
		int lr;
		int k;
		int mode;
		sample_item_t it;
		hr = axis_root(thr_high);
		lr = axis_root(thr_low);
		k = 0;
		while (k < n) begin
			mode = $urandom_range(0, 99);
			if (mode < 70) begin
				repeat ($urandom_range(1, 4)) begin
					items_to_send.push_back(dominant_sample(hr + $urandom_range(0, 400), 40));
					k++;
				end
				repeat ($urandom_range(1, 5)) begin
					items_to_send.push_back(dominant_sample($urandom_range(0, lr), 40));
					k++;
				end
			end else begin
				if (mode < 84) begin
					it = mk_item(OP_SAMPLE, $urandom, $urandom, $urandom);
				end else if (mode < 90) begin
					// right at a threshold, equality included
					it = dominant_sample((mode < 87 ? hr : lr)
						+ int'($urandom_range(0, 4)) - 2, 0);
				end else if (mode < 95) begin
					it.op = OP_SAMPLE;
					it.ax = corner_axis();
					it.ay = corner_axis();
					it.az = corner_axis();
				end else begin
					it = mk_item(OP_CLEAR, $urandom, $urandom, $urandom);
				end
				items_to_send.push_back(it);
				k++;
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic writes_done();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		do @(negedge clk); while (!drained);
	endtask

	// driver: new values at the falling edge, source gaps and sink stalls in bursts
	always @(negedge clk) begin
		sample_item_t cur;
		if (arst_n) begin
			if (!s_axis_tvalid || src_took) begin
				if (src_gap == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
					src_gap = $urandom_range(1, 4);
				end
				if (src_gap > 0 || items_to_send.size() == 0) begin
					if (src_gap > 0) begin
						src_gap--;
					end
					s_axis_tvalid <= 1'b0;
				end else begin
					cur = items_to_send.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {cur.az, cur.ay, cur.ax};
					s_axis_tuser <= cur.op;
				end
			end
			if (snk_gap == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				snk_gap = $urandom_range(1, 4);
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor: register writes, accepted items and results, all at the rising edge
	always @(posedge clk) begin
		sample_item_t got_in;
		step_result_t want;
		step_result_t seen;
		src_took = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HIGH_THR: thr_high = cfg_data;
					REG_LOW_THR:  thr_low = cfg_data;
					REG_COOLDOWN: cool_reload = cfg_data[COOL_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				src_took = 1'b1;
				got_in = sample_item_t'({s_axis_tuser, s_axis_tdata});
				results_due.push_back(predict_step(got_in));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen = step_result_t'(m_axis_tdata[45:0]);
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result,", $time,
						" got total %0d motion %0d active %0b counted %0b",
						seen.total, seen.motion, seen.in_progress, seen.counted);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					if (seen != want) begin
						$display("%0t: mismatch,", $time,
							" expected total %0d motion %0d active %0b counted %0b,",
							want.total, want.motion, want.in_progress, want.counted,
							" got total %0d motion %0d active %0b counted %0b",
							seen.total, seen.motion, seen.in_progress, seen.counted);
						mismatches++;
					end
				end
			end
			drained = items_to_send.size() == 0 && !(s_axis_tvalid && !s_axis_tready)
				&& results_due.size() == 0;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset thresholds: 20494^2 just above high, 18165^2 just below low
		stall_pct = 25;
		items_to_send.push_back(mk_item(OP_SAMPLE, 0, 0, 0));
		items_to_send.push_back(mk_item(OP_CLEAR, 0, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 20493, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 20494, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 0, 0, -32768));
		items_to_send.push_back(mk_item(OP_SAMPLE, 18166, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 0, -18165, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, -32768, -32768, -32768));
		// clear with junk axes keeps the active flag and the held level
		items_to_send.push_back(mk_item(OP_CLEAR, 32767, -1, 12345));
		items_to_send.push_back(mk_item(OP_SAMPLE, 32767, 32767, 32767));
		items_to_send.push_back(mk_item(OP_SAMPLE, 1, -1, 1));
		items_to_send.push_back(mk_item(OP_SAMPLE, -1, -1, -1));
		items_to_send.push_back(mk_item(OP_SAMPLE, 16'h5555, 16'hAAAA, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 0, 0, 0));
		// cooldown just ran out, counts right away
		items_to_send.push_back(mk_item(OP_SAMPLE, -32768, 0, 0));
		items_to_send.push_back(mk_item(OP_CLEAR, 0, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 0, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, -32767, 32767, -32768));
		queue_random(200);
		wait_drained();

		// exact squares on both thresholds, no cooldown, spare index dropped
		write_reg(REG_HIGH_THR, 32'd400000000);
		write_reg(REG_LOW_THR, 32'd100000000);
		write_reg(REG_COOLDOWN, 32'd0);
		write_reg(REG_SPARE, 32'hDEADBEEF);
		writes_done();
		stall_pct = 40;
		items_to_send.push_back(mk_item(OP_SAMPLE, 20000, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 0, 20001, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 0, 0, 10000));
		items_to_send.push_back(mk_item(OP_SAMPLE, 9999, 0, 0));
		items_to_send.push_back(mk_item(OP_SAMPLE, 20001, 0, 0));
		queue_random(250);
		wait_drained();

		// zero thresholds: a step never ends, longest cooldown
		write_reg(REG_HIGH_THR, 32'd0);
		write_reg(REG_LOW_THR, 32'd0);
		write_reg(REG_COOLDOWN, 32'd255);
		writes_done();
		stall_pct = 0;
		queue_random(150);
		wait_drained();

		// top of the magnitude range
		write_reg(REG_HIGH_THR, 32'd3221225472);
		write_reg(REG_LOW_THR, 32'd3221225472);
		write_reg(REG_COOLDOWN, 32'd2);
		writes_done();
		stall_pct = 10;
		queue_random(100);
		wait_drained();

		// out-of-range high threshold can never be crossed
		write_reg(REG_HIGH_THR, 32'hFFFFFFFF);
		write_reg(REG_LOW_THR, 32'd0);
		write_reg(REG_COOLDOWN, 32'd1);
		writes_done();
		stall_pct = 60;
		queue_random(50);
		wait_drained();

		// random thresholds, low under high
		write_reg(REG_LOW_THR, $urandom_range(0, 1000000000));
		write_reg(REG_HIGH_THR, $urandom_range(1000000000, 2000000000));
		write_reg(REG_COOLDOWN, $urandom_range(0, 7));
		writes_done();
		stall_pct = 20;
		queue_random(300);
		wait_drained();

		// back near the defaults, full rate on both sides
		write_reg(REG_HIGH_THR, HIGH_THR_RESET);
		write_reg(REG_LOW_THR, LOW_THR_RESET);
		write_reg(REG_COOLDOWN, 32'd5);
		writes_done();
		stall_pct = 0;
		queue_random(300);
		wait_drained();

		// wait past the pipeline depth to catch stray results
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
